// ----- src/pid_pkg.sv -----
// Shared types and constants for the PID step block with clamps.
// No dependencies; every other file imports this package.
package pid_pkg;

  localparam int unsigned GAIN_W     = 16;  // unsigned Q8.8
  localparam int unsigned LIMIT_W    = 15;  // unsigned integer limits
  localparam int unsigned SAMPLE_W   = 16;  // signed error and result fields
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned ACCUM_W    = 25;  // signed Q16.8
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 16'd256;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd256;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd256;
  localparam logic [LIMIT_W-1:0] INT_LIMIT_RST   = 15'd100;
  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST   = 15'd255;
  localparam logic [LIMIT_W-1:0] NOISE_LEVEL_RST = 15'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_D         = 3'd1,
    CFG_GAIN_I         = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_OUTPUT_LIMIT   = 3'd4,
    CFG_NOISE_LEVEL    = 3'd5
  } pid_cfg_idx_t;

  typedef enum logic {
    ACT_STEP  = 1'b0,
    ACT_CLEAR = 1'b1
  } pid_action_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_d;
    logic [GAIN_W-1:0]  gain_i;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] output_limit;
    logic [LIMIT_W-1:0] noise_level;
  } pid_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] drive_value;
    logic signed [SAMPLE_W-1:0] integral_term;
  } pid_result_t;

endpackage

// ----- src/pid_ifs.sv -----
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on pid_pkg for field widths.
interface pid_in_if
  import pid_pkg::*;
  ;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [SAMPLE_W-1:0] error_sample;

  modport source (output valid, output action, output error_sample, input ready);
  modport sink   (input valid, input action, input error_sample, output ready);
endinterface

interface pid_out_if
  import pid_pkg::*;
  ;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] drive_value;
  logic signed [SAMPLE_W-1:0] integral_term;

  modport source (output valid, output drive_value, output integral_term, input ready);
  modport sink   (input valid, input drive_value, input integral_term, output ready);
endinterface

// ----- src/pid_cfg_regs.sv -----
// Configuration register file: gains, integral and output limits, noise level.
// Depends on pid_pkg.
module pid_cfg_regs
  import pid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output pid_cfg_t              cfg
);

  pid_cfg_t cfg_r;
  pid_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (pid_cfg_idx_t'(cfg_index))
        CFG_GAIN_P:         cfg_nxt.gain_p         = cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_D:         cfg_nxt.gain_d         = cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_I:         cfg_nxt.gain_i         = cfg_wdata[GAIN_W-1:0];
        CFG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = cfg_wdata[LIMIT_W-1:0];
        CFG_OUTPUT_LIMIT:   cfg_nxt.output_limit   = cfg_wdata[LIMIT_W-1:0];
        CFG_NOISE_LEVEL:    cfg_nxt.noise_level    = cfg_wdata[LIMIT_W-1:0];
        default:            cfg_nxt = cfg_r;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= GAIN_P_RST;
      cfg_r.gain_d         <= GAIN_D_RST;
      cfg_r.gain_i         <= GAIN_I_RST;
      cfg_r.integral_limit <= INT_LIMIT_RST;
      cfg_r.output_limit   <= OUT_LIMIT_RST;
      cfg_r.noise_level    <= NOISE_LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/pid_datapath.sv -----
// One PID step or clear: three gain products, integral clamp, sum, truncation,
// output saturation and deadband. Purely combinational; depends on pid_pkg.
module pid_datapath
  import pid_pkg::*;
(
  input  pid_cfg_t                   cfg,
  input  logic                       action,
  input  logic signed [SAMPLE_W-1:0] error_sample,
  input  logic signed [ACCUM_W-1:0]  accum,
  input  logic signed [SAMPLE_W-1:0] prev_error,
  output logic signed [ACCUM_W-1:0]  accum_nxt,
  output logic signed [SAMPLE_W-1:0] prev_error_nxt,
  output pid_result_t                result
);

  logic signed [GAIN_W:0]    gp_s, gd_s, gi_s;
  logic signed [SAMPLE_W:0]  diff;
  logic signed [32:0]        prop;
  logic signed [33:0]        deriv;
  logic signed [32:0]        iprod;
  logic signed [33:0]        acc_raw;
  logic signed [33:0]        ilim;
  logic signed [ACCUM_W-1:0] acc_cl;
  logic signed [35:0]        sum;
  logic                      sum_round;
  logic signed [27:0]        drive_tr;
  logic signed [27:0]        olim;
  logic signed [SAMPLE_W-1:0] drive_sat;
  logic signed [SAMPLE_W:0]  drive_ext;
  logic signed [SAMPLE_W:0]  noise;
  logic                      acc_round;
  logic signed [16:0]        iterm;

  assign gp_s = $signed({1'b0, cfg.gain_p});
  assign gd_s = $signed({1'b0, cfg.gain_d});
  assign gi_s = $signed({1'b0, cfg.gain_i});

  assign diff  = {error_sample[SAMPLE_W-1], error_sample}
               - {prev_error[SAMPLE_W-1], prev_error};
  assign prop  = error_sample * gp_s;
  assign deriv = diff * gd_s;
  assign iprod = error_sample * gi_s;

  assign acc_raw = {{9{accum[ACCUM_W-1]}}, accum} + {iprod[32], iprod};
  assign ilim    = $signed({11'b0, cfg.integral_limit, 8'b0});

  always_comb begin
    priority if (acc_raw > ilim) begin
      acc_cl = ilim[ACCUM_W-1:0];
    end else if (acc_raw < -ilim) begin
      acc_cl = -ilim[ACCUM_W-1:0];
    end else begin
      acc_cl = acc_raw[ACCUM_W-1:0];
    end
  end

  assign sum = {{3{prop[32]}}, prop} + {{2{deriv[33]}}, deriv}
             + {{11{acc_cl[ACCUM_W-1]}}, acc_cl};

  // Truncate toward zero: bump the floor of a negative value with a fraction.
  assign sum_round = sum[35] && (sum[FRAC_W-1:0] != '0);
  assign drive_tr  = sum[35:FRAC_W] + {27'b0, sum_round};
  assign olim      = $signed({13'b0, cfg.output_limit});

  always_comb begin
    priority if (drive_tr > olim) begin
      drive_sat = olim[SAMPLE_W-1:0];
    end else if (drive_tr < -olim) begin
      drive_sat = -olim[SAMPLE_W-1:0];
    end else begin
      drive_sat = drive_tr[SAMPLE_W-1:0];
    end
  end

  assign drive_ext = {drive_sat[SAMPLE_W-1], drive_sat};
  assign noise     = $signed({2'b0, cfg.noise_level});

  assign acc_round = acc_cl[ACCUM_W-1] && (acc_cl[FRAC_W-1:0] != '0);
  assign iterm     = acc_cl[ACCUM_W-1:FRAC_W] + {16'b0, acc_round};

  always_comb begin
    if (action == ACT_CLEAR) begin
      accum_nxt            = '0;
      prev_error_nxt       = '0;
      result.drive_value   = '0;
      result.integral_term = '0;
    end else begin
      accum_nxt            = acc_cl;
      prev_error_nxt       = error_sample;
      result.integral_term = iterm[SAMPLE_W-1:0];
      if (drive_ext < noise && drive_ext > -noise) begin
        result.drive_value = '0;
      end else begin
        result.drive_value = drive_sat;
      end
    end
  end

endmodule

// ----- src/pid_step_with_clamps.sv -----
// PID controller step with integral clamp, output saturation and deadband.
// Depends on pid_pkg, pid_ifs, pid_cfg_regs and pid_datapath.
//
// Usage:
//   in_ch carries one item per handshake: action (0 step, 1 clear) and a
//   signed error_sample. out_ch returns exactly one result per input item:
//   drive_value and integral_term, in input order.
//   cfg_we/cfg_index/cfg_wdata write the gain, limit and noise registers;
//   write only while no item is in flight.
// Timing:
//   An accepted item is held in the input register while the output
//   register is full and stalled, then its result is loaded into the output
//   register, which drives out_ch.valid. Throughput is one item per cycle
//   while out_ch.ready stays high; the integral is updated combinationally
//   between the two registers.
// Reset:
//   Synchronous, active low. Config registers return to their defaults, the
//   integral and previous error go to zero, and both channels are empty.
// Backpressure:
//   While out_ch.ready is low the result holds; in_ch.ready stays high
//   until the input register also holds an item, so at most two items wait.
module pid_step_with_clamps
  import pid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  pid_in_if.sink                in_ch,
  pid_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  pid_cfg_t cfg;

  logic                       in_valid_r;
  logic                       in_action_r;
  logic signed [SAMPLE_W-1:0] in_error_r;
  logic                       out_valid_r;
  pid_result_t                out_result_r;
  logic signed [ACCUM_W-1:0]  accum_r;
  logic signed [SAMPLE_W-1:0] prev_error_r;

  logic signed [ACCUM_W-1:0]  accum_nxt;
  logic signed [SAMPLE_W-1:0] prev_error_nxt;
  pid_result_t                result_nxt;
  logic                       advance;
  logic                       in_take;

  pid_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pid_datapath u_dp (
    .cfg            (cfg),
    .action         (in_action_r),
    .error_sample   (in_error_r),
    .accum          (accum_r),
    .prev_error     (prev_error_r),
    .accum_nxt      (accum_nxt),
    .prev_error_nxt (prev_error_nxt),
    .result         (result_nxt)
  );

  // Advance the held item whenever the output register is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready          = !in_valid_r || advance;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_value   = out_result_r.drive_value;
  assign out_ch.integral_term = out_result_r.integral_term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      accum_r      <= '0;
      prev_error_r <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        accum_r      <= accum_nxt;
        prev_error_r <= prev_error_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action_r <= in_ch.action;
      in_error_r  <= in_ch.error_sample;
    end
    if (advance) begin
      out_result_r <= result_nxt;
    end
  end

  a_clear_zeroes_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_action_r == ACT_CLEAR) |=> (accum_r == '0) && (prev_error_r == '0))
    else $error("state not cleared after clear item");

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled while output register empty");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(accum_r) && $stable(prev_error_r))
    else $error("controller state changed during output stall");

  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_result_r.drive_value != 16'sh8000))
    else $error("drive value outside symmetric range");

endmodule
